// File: design/chained_fixup_pointer_rewrite_macros.svh
// Assertion macros for the chained fixup pointer rewrite block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef CHAINED_FIXUP_POINTER_REWRITE_MACROS_SVH
`define CHAINED_FIXUP_POINTER_REWRITE_MACROS_SVH

// plain implication, sampled at every edge
`define CFP_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("cfp: check failed");

// implication qualified by a result word on the output
`define CFP_ASSERT_RESULT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (result.valid && (cond)) |-> (prop)) else $error("cfp: bad result word");

`endif

// File: design/cfp_pkg.sv
// Shared types and codes for the chained fixup pointer rewrite block.
// No dependencies.
package cfp_pkg;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_FIX  = 1'b1;

    localparam logic FMT_VMADDR         = 1'b0;
    localparam logic FMT_RUNTIME_OFFSET = 1'b1;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef enum logic [2:0] {
        CFG_PREFERRED_BASE = 3'd0,
        CFG_LOADED_BASE    = 3'd1,
        CFG_POINTER_FORMAT = 3'd2,
        CFG_PAGE_SIZE      = 3'd3,
        CFG_IMPORT_COUNT   = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_OUTSIDE     = 3'd1,
        ST_BAD_IMPORT  = 3'd2,
        ST_UNRESOLVED  = 3'd3,
        ST_OVERFLOW    = 3'd4,
        ST_SLIDE_FAIL  = 3'd5,
        ST_NEXT_LEAVES = 3'd6
    } status_t;

    typedef struct packed {
        logic [63:0] loaded_base;
        logic [63:0] gap;
        logic        gap_ge;
        logic        pointer_format;
        logic [15:0] page_size;
        logic [12:0] import_count;
    } cfg_t;

    // one word between front and back
    typedef struct packed {
        logic        is_fix;
        status_t     pre_st;
        logic [63:0] op_a;
        logic [63:0] op_b;
        logic        op_sub;
        logic        op_chk;
        status_t     fail_st;
        logic        keep_hi;
        logic [7:0]  hi;
        logic        nxt_zero;
        logic        leaves;
        logic [15:0] next_off;
    } qent_t;

endpackage

// File: design/cfp_ifs.sv
// Handshake channel interfaces: item input, result output, config writes.
// Depends on nothing.
interface cfp_item_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [11:0] import_slot;
    logic [63:0] import_target;
    logic [63:0] import_addend;
    logic        import_weak;
    logic [63:0] raw_pointer;
    logic [15:0] offset_in_page;

    modport source (output valid, kind, import_slot, import_target, import_addend,
                    import_weak, raw_pointer, offset_in_page, input ready);
    modport sink (input valid, kind, import_slot, import_target, import_addend,
                  import_weak, raw_pointer, offset_in_page, output ready);
endinterface

interface cfp_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] fixed_value;
    logic [15:0] next_offset;
    logic        chain_end;
    logic [2:0]  status;

    modport source (output valid, fixed_value, next_offset, chain_end, status,
                    input ready);
    modport sink (input valid, fixed_value, next_offset, chain_end, status,
                  output ready);
endinterface

interface cfp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: design/cfp_front.sv
// Front end: accepts words, checks page and import range, owns the import table.
// Depends on cfp_pkg and cfp_item_if.
module cfp_front #(
    parameter int IMPORT_DEPTH = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cfp_pkg::cfg_t cfg,
    cfp_item_if.sink      item,
    output logic          push,
    output cfp_pkg::qent_t push_data,
    input  logic          push_ready
);

    localparam int IDX_W = (IMPORT_DEPTH > 1) ? $clog2(IMPORT_DEPTH) : 1;
    localparam logic [24:0] DEPTH_L = 25'(IMPORT_DEPTH);

    typedef struct packed {
        logic [63:0] target;
        logic [63:0] addend;
        logic        is_weak;
    } imp_t;

    typedef struct packed {
        logic            is_fix;
        logic            is_bind;
        cfp_pkg::status_t pre_st;
        logic [7:0]      inl;
        logic [35:0]     tgt;
        logic [7:0]      hi;
        logic            nxt_zero;
        logic            leaves;
        logic [15:0]     next_off;
    } stage_t;

    imp_t mem [IMPORT_DEPTH];
    imp_t rdata_reg;

    stage_t      s0;
    stage_t      s1_reg;
    logic        s1_valid_reg;
    logic        accept;
    logic [63:0] raw;
    logic [15:0] off;
    logic [23:0] idx;
    logic [11:0] nxt;
    logic [15:0] nxt_bytes;
    logic [15:0] room;
    logic        page_err;
    logic        idx_in_depth;
    logic        bad_import;
    logic        wr_en;
    logic        rd_en;
    logic [63:0] bind_sum;
    logic        unresolved;

    assign item.ready = !s1_valid_reg || push_ready;
    assign accept     = item.valid && item.ready;

    assign raw          = item.raw_pointer;
    assign off          = item.offset_in_page;
    assign idx          = raw[23:0];
    assign nxt          = raw[62:51];
    assign nxt_bytes    = {2'b00, nxt, 2'b00};
    assign room         = cfg.page_size - off;
    assign page_err     = ({1'b0, off} + 17'd8) > {1'b0, cfg.page_size};
    assign idx_in_depth = {1'b0, idx} < DEPTH_L;
    assign bad_import   = !idx_in_depth || (idx >= 24'(cfg.import_count));

    always_comb
    begin
        s0.is_fix   = (item.kind == cfp_pkg::KIND_FIX);
        s0.is_bind  = raw[63];
        s0.inl      = raw[31:24];
        s0.tgt      = raw[35:0];
        s0.hi       = raw[43:36];
        s0.nxt_zero = (nxt == 12'd0);
        s0.leaves   = nxt_bytes > room;
        s0.next_off = off + nxt_bytes;
        if (page_err)
        begin
            s0.pre_st = cfp_pkg::ST_OUTSIDE;
        end
        else if (raw[63] && bad_import)
        begin
            s0.pre_st = cfp_pkg::ST_BAD_IMPORT;
        end
        else
        begin
            s0.pre_st = cfp_pkg::ST_OK;
        end
    end

    assign wr_en = accept && (item.kind == cfp_pkg::KIND_LOAD)
                   && (25'(item.import_slot) < DEPTH_L);
    assign rd_en = accept && (item.kind == cfp_pkg::KIND_FIX) && raw[63] && idx_in_depth;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[IDX_W'(item.import_slot)] <= '{target:  item.import_target,
                                               addend:  item.import_addend,
                                               is_weak: item.import_weak};
        end
        if (rd_en)
        begin
            rdata_reg <= mem[IDX_W'(idx)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s0;
        end
    end

    assign bind_sum   = rdata_reg.target + rdata_reg.addend;
    assign unresolved = (rdata_reg.target == 64'd0) && !rdata_reg.is_weak;
    assign push       = s1_valid_reg;

    always_comb
    begin
        push_data.is_fix   = s1_reg.is_fix;
        push_data.pre_st   = s1_reg.pre_st;
        push_data.hi       = s1_reg.hi;
        push_data.nxt_zero = s1_reg.nxt_zero;
        push_data.leaves   = s1_reg.leaves;
        push_data.next_off = s1_reg.next_off;
        if (s1_reg.is_bind)
        begin
            if (s1_reg.pre_st == cfp_pkg::ST_OK && unresolved)
            begin
                push_data.pre_st = cfp_pkg::ST_UNRESOLVED;
            end
            push_data.op_a    = bind_sum;
            push_data.op_b    = {56'd0, s1_reg.inl};
            push_data.op_sub  = 1'b0;
            push_data.op_chk  = 1'b0;
            push_data.fail_st = cfp_pkg::ST_OK;
            push_data.keep_hi = 1'b0;
        end
        else if (cfg.pointer_format == cfp_pkg::FMT_RUNTIME_OFFSET)
        begin
            push_data.op_a    = cfg.loaded_base;
            push_data.op_b    = {s1_reg.hi, 20'd0, s1_reg.tgt};
            push_data.op_sub  = 1'b0;
            push_data.op_chk  = 1'b1;
            push_data.fail_st = cfp_pkg::ST_OVERFLOW;
            push_data.keep_hi = 1'b0;
        end
        else
        begin
            push_data.op_a    = {28'd0, s1_reg.tgt};
            push_data.op_b    = cfg.gap;
            push_data.op_sub  = !cfg.gap_ge;
            push_data.op_chk  = 1'b1;
            push_data.fail_st = cfp_pkg::ST_SLIDE_FAIL;
            push_data.keep_hi = 1'b1;
        end
    end

endmodule

// File: design/cfp_fifo.sv
// Two-entry queue between front and back ends.
// Depends on cfp_pkg.
module cfp_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  cfp_pkg::qent_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output cfp_pkg::qent_t pop_data
);

    cfp_pkg::qent_t                 entry_reg [cfp_pkg::Q_DEPTH];
    logic [cfp_pkg::Q_PTR_W-1:0]    wr_ptr_reg;
    logic [cfp_pkg::Q_PTR_W-1:0]    wr_ptr_next;
    logic [cfp_pkg::Q_PTR_W-1:0]    rd_ptr_reg;
    logic [cfp_pkg::Q_PTR_W-1:0]    rd_ptr_next;
    logic [cfp_pkg::Q_CNT_W-1:0]    cnt_reg;
    logic [cfp_pkg::Q_CNT_W-1:0]    cnt_next;
    logic                           do_push;
    logic                           do_pop;

    assign push_ready = cnt_reg != cfp_pkg::Q_CNT_W'(cfp_pkg::Q_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + cfp_pkg::Q_CNT_W'(do_push) - cfp_pkg::Q_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/cfp_back.sv
// Back end: final add with carry check, chain result and output register.
// Depends on cfp_pkg and cfp_result_if.
module cfp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  cfp_pkg::qent_t pop_data,
    cfp_result_if.source   result
);

    logic             out_valid_reg;
    logic [63:0]      fixed_value_reg;
    logic [63:0]      fixed_value_next;
    logic [15:0]      next_offset_reg;
    logic [15:0]      next_offset_next;
    logic             chain_end_reg;
    logic             chain_end_next;
    cfp_pkg::status_t status_reg;
    cfp_pkg::status_t status_next;
    logic             take;
    logic [63:0]      b_eff;
    logic [64:0]      sum;
    logic             fail;
    logic [63:0]      value;

    assign pop_ready = !out_valid_reg || result.ready;
    assign take      = pop_valid && pop_ready;

    // subtract as a + ~b + 1; carry out clear means borrow
    assign b_eff = pop_data.op_sub ? ~pop_data.op_b : pop_data.op_b;
    assign sum   = {1'b0, pop_data.op_a} + {1'b0, b_eff} + 65'(pop_data.op_sub);
    assign fail  = pop_data.op_chk && (sum[64] ^ pop_data.op_sub);
    assign value = pop_data.keep_hi ? {pop_data.hi, sum[55:0]} : sum[63:0];

    always_comb
    begin
        fixed_value_next = 64'd0;
        next_offset_next = 16'd0;
        chain_end_next   = 1'b1;
        status_next      = cfp_pkg::ST_OK;
        if (!pop_data.is_fix)
        begin
            chain_end_next = 1'b0;
        end
        else if (pop_data.pre_st != cfp_pkg::ST_OK)
        begin
            status_next = pop_data.pre_st;
        end
        else if (fail)
        begin
            status_next = pop_data.fail_st;
        end
        else
        begin
            fixed_value_next = value;
            if (pop_data.nxt_zero)
            begin
                status_next = cfp_pkg::ST_OK;
            end
            else if (pop_data.leaves)
            begin
                status_next = cfp_pkg::ST_NEXT_LEAVES;
            end
            else
            begin
                next_offset_next = pop_data.next_off;
                chain_end_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop_ready)
        begin
            out_valid_reg <= pop_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            fixed_value_reg <= fixed_value_next;
            next_offset_reg <= next_offset_next;
            chain_end_reg   <= chain_end_next;
            status_reg      <= status_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.fixed_value = fixed_value_reg;
    assign result.next_offset = next_offset_reg;
    assign result.chain_end   = chain_end_reg;
    assign result.status      = status_reg;

endmodule

// File: design/chained_fixup_pointer_rewrite.sv
// Top level: config registers, front end, queue and back end.
// Depends on cfp_pkg, cfp_ifs, cfp_front, cfp_fifo, cfp_back and the macro header.
//
//   channel  dir  fields
//   cfg      in   index, data (one register word per write)
//   item     in   kind, import_slot, import_target, import_addend, import_weak,
//                 raw_pointer, offset_in_page
//   result   out  fixed_value, next_offset, chain_end, status
//
// One word per cycle while the result side is ready; each result passes through the table
// read stage, the queue and the output register. The import table is a single-port
// read, single-port write memory; a load may be followed by a bind on the next cycle.
// Reset clears control and config registers only; the table is not cleared.
// Either side may stall; the two-entry queue lets front and back stall separately.
`include "chained_fixup_pointer_rewrite_macros.svh"

module chained_fixup_pointer_rewrite #(
    parameter int IMPORT_DEPTH = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    cfp_cfg_if.sink       cfg,
    cfp_item_if.sink      item,
    cfp_result_if.source  result
);

    logic [63:0]    preferred_base_reg;
    logic [63:0]    loaded_base_reg;
    logic           pointer_format_reg;
    logic [15:0]    page_size_reg;
    logic [12:0]    import_count_reg;
    logic [63:0]    gap_reg;
    logic           gap_ge_reg;
    logic [64:0]    up_diff;
    logic [63:0]    down_diff;
    cfp_pkg::cfg_t  cfg_bus;

    logic           q_push;
    logic           q_push_ready;
    cfp_pkg::qent_t q_push_data;
    logic           q_pop_valid;
    logic           q_pop_ready;
    cfp_pkg::qent_t q_pop_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preferred_base_reg <= 64'd0;
            loaded_base_reg    <= 64'd0;
            pointer_format_reg <= cfp_pkg::FMT_VMADDR;
            page_size_reg      <= 16'd16384;
            import_count_reg   <= 13'd0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                cfp_pkg::CFG_PREFERRED_BASE: preferred_base_reg <= cfg.data;
                cfp_pkg::CFG_LOADED_BASE:    loaded_base_reg    <= cfg.data;
                cfp_pkg::CFG_POINTER_FORMAT: pointer_format_reg <= cfg.data[0];
                cfp_pkg::CFG_PAGE_SIZE:      page_size_reg      <= cfg.data[15:0];
                cfp_pkg::CFG_IMPORT_COUNT:   import_count_reg   <= cfg.data[12:0];
                default:                     ;
            endcase
        end
    end

    // slide distance, registered in gap_reg from the two base registers
    assign up_diff   = {1'b0, loaded_base_reg} - {1'b0, preferred_base_reg};
    assign down_diff = preferred_base_reg - loaded_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg    <= 64'd0;
            gap_ge_reg <= 1'b1;
        end
        else
        begin
            gap_reg    <= up_diff[64] ? down_diff : up_diff[63:0];
            gap_ge_reg <= !up_diff[64];
        end
    end

    always_comb
    begin
        cfg_bus.loaded_base    = loaded_base_reg;
        cfg_bus.gap            = gap_reg;
        cfg_bus.gap_ge         = gap_ge_reg;
        cfg_bus.pointer_format = pointer_format_reg;
        cfg_bus.page_size      = page_size_reg;
        cfg_bus.import_count   = import_count_reg;
    end

    cfp_front #(
        .IMPORT_DEPTH (IMPORT_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_bus),
        .item       (item),
        .push       (q_push),
        .push_data  (q_push_data),
        .push_ready (q_push_ready)
    );

    cfp_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    cfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_data  (q_pop_data),
        .result    (result)
    );

    // front only stalls while the queue is full and a result word is waiting
    `CFP_ASSERT_NOW(a_stall_backpressure, !item.ready, result.valid && !q_push_ready)
    `CFP_ASSERT_RESULT(a_open_chain_ok, !result.chain_end, result.status == cfp_pkg::ST_OK)
    `CFP_ASSERT_RESULT(a_error_zero, result.status != cfp_pkg::ST_OK && result.status != cfp_pkg::ST_NEXT_LEAVES, result.fixed_value == 64'd0 && result.next_offset == 16'd0 && result.chain_end)
    `CFP_ASSERT_RESULT(a_leaves_ends, result.status == cfp_pkg::ST_NEXT_LEAVES, result.next_offset == 16'd0 && result.chain_end)

endmodule

// File: verif/chained_fixup_pointer_rewrite_tb.sv
`timescale 1ns / 100ps
// Testbench for chained_fixup_pointer_rewrite: import loads and pointer fixes, directed then
// random, checked word by word against an in-bench predictor of the rewrite rules.
// Depends on cfp_pkg, cfp_ifs and the block's RTL.
module chained_fixup_pointer_rewrite_tb;
    import cfp_pkg::*;

    localparam int TABLE_DEPTH = 4096;
    localparam int PHASES = 7;
    localparam int RANDOM_PER_PHASE = 145;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic        kind;
        logic [11:0] slot;
        logic [63:0] target;
        logic [63:0] addend;
        logic        is_weak;
        logic [63:0] raw;
        logic [15:0] off;
    } item_word_t;

    typedef struct {
        logic [63:0] value;
        logic [15:0] next_off;
        logic        chain_end;
        logic [2:0]  status;
    } fixup_result_t;

    class fixup_scoreboard;
        logic [63:0] target_tbl [TABLE_DEPTH];
        logic [63:0] addend_tbl [TABLE_DEPTH];
        bit          weak_tbl [TABLE_DEPTH];
        bit          loaded [TABLE_DEPTH];
        int          loaded_slots [$];

        logic [63:0] preferred_base = '0;
        logic [63:0] loaded_base = '0;
        logic        pointer_format = FMT_VMADDR;
        logic [15:0] page_size = 16'd16384;
        logic [12:0] import_count = '0;

        fixup_result_t expected_q [$];
        int failures;
        int loads_seen;
        int fixes_seen;
        int status_seen [8];

        function void set_reg(cfg_index_t idx, logic [63:0] data);
            case (idx)
                CFG_PREFERRED_BASE: preferred_base = data;
                CFG_LOADED_BASE:    loaded_base = data;
                CFG_POINTER_FORMAT: pointer_format = data[0];
                CFG_PAGE_SIZE:      page_size = data[15:0];
                CFG_IMPORT_COUNT:   import_count = data[12:0];
                default: ;
            endcase
        endfunction

        function fixup_result_t predict_fix(logic [63:0] raw, logic [15:0] off);
            fixup_result_t res;
            status_t       st;
            logic [63:0]   val;
            logic [63:0]   tgt64;
            logic [63:0]   gap;
            logic [63:0]   enc;
            logic [63:0]   slid;
            logic [23:0]   idx;
            int unsigned   nxt;
            int unsigned   ps;
            int unsigned   ou;
            st = ST_OK;
            val = '0;
            ps = page_size;
            ou = off;
            if (ou + 8 > ps)
            begin
                st = ST_OUTSIDE;
            end
            else if (raw[63])
            begin
                idx = raw[23:0];
                if (idx >= import_count || idx >= TABLE_DEPTH)
                    st = ST_BAD_IMPORT;
                else if (target_tbl[idx] == 64'd0 && !weak_tbl[idx])
                    st = ST_UNRESOLVED;
                else
                    val = target_tbl[idx] + addend_tbl[idx] + 64'(raw[31:24]);
            end
            else
            begin
                tgt64 = 64'(raw[35:0]);
                if (pointer_format == FMT_RUNTIME_OFFSET)
                begin
                    enc = tgt64 | {raw[43:36], 56'd0};
                    if (enc > ~loaded_base)
                        st = ST_OVERFLOW;
                    else
                        val = loaded_base + enc;
                end
                else
                begin
                    if (loaded_base >= preferred_base)
                    begin
                        gap = loaded_base - preferred_base;
                        if (gap > ~tgt64)
                            st = ST_SLIDE_FAIL;
                        slid = tgt64 + gap;
                    end
                    else
                    begin
                        gap = preferred_base - loaded_base;
                        if (tgt64 < gap)
                            st = ST_SLIDE_FAIL;
                        slid = tgt64 - gap;
                    end
                    val = {raw[43:36], slid[55:0]};
                end
            end
            nxt = raw[62:51];
            res.value = val;
            res.next_off = '0;
            res.chain_end = 1'b1;
            if (st != ST_OK)
            begin
                res.value = '0;
            end
            else if (nxt != 0)
            begin
                if (nxt > (ps - ou) / 4)
                begin
                    st = ST_NEXT_LEAVES;
                end
                else
                begin
                    res.next_off = 16'(ou + nxt * 4);
                    res.chain_end = 1'b0;
                end
            end
            res.status = st;
            return res;
        endfunction

        function void note_item(item_word_t w);
            fixup_result_t res;
            if (w.kind == KIND_LOAD)
            begin
                target_tbl[w.slot] = w.target;
                addend_tbl[w.slot] = w.addend;
                weak_tbl[w.slot] = w.is_weak;
                if (!loaded[w.slot])
                begin
                    loaded[w.slot] = 1'b1;
                    loaded_slots.insert(loaded_slots.size(), int'(w.slot));
                end
                res.value = '0;
                res.next_off = '0;
                res.chain_end = 1'b0;
                res.status = ST_OK;
                loads_seen++;
            end
            else
            begin
                res = predict_fix(w.raw, w.off);
                fixes_seen++;
            end
            expected_q.insert(expected_q.size(), res);
        endfunction

        function void check_result(logic [63:0] value, logic [15:0] next_off,
                                   logic chain_end, logic [2:0] status);
            fixup_result_t exp_word;
            if (expected_q.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("%0t: result word with nothing pending: ", $time,
                             "value %h next %0d end %0b status %0d",
                             value, next_off, chain_end, status);
                return;
            end
            exp_word = expected_q.pop_front();
            status_seen[exp_word.status]++;
            if (value !== exp_word.value || next_off !== exp_word.next_off ||
                chain_end !== exp_word.chain_end || status !== exp_word.status)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("%0t: mismatch: expected value %h next %0d end %0b status %0d, ",
                             $time, exp_word.value, exp_word.next_off, exp_word.chain_end,
                             exp_word.status,
                             "got value %h next %0d end %0b status %0d",
                             value, next_off, chain_end, status);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned chain_off = 0;
    fixup_scoreboard sb = new;

    cfp_item_if   item_ch ();
    cfp_result_if result_ch ();
    cfp_cfg_if    cfg_ch ();

    chained_fixup_pointer_rewrite #(.IMPORT_DEPTH(TABLE_DEPTH)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] bind_word(logic [23:0] idx, logic [7:0] inl,
                                              logic [11:0] nxt);
        return {1'b1, nxt, 19'($urandom), inl, idx};
    endfunction

    function automatic logic [63:0] rebase_word(logic [35:0] tgt, logic [7:0] hi,
                                                logic [11:0] nxt);
        return {1'b0, nxt, 7'($urandom), hi, tgt};
    endfunction

    function automatic item_word_t load_word(logic [11:0] slot, logic [63:0] target,
                                             logic [63:0] addend, logic is_weak);
        item_word_t w;
        w.kind = KIND_LOAD;
        w.slot = slot;
        w.target = target;
        w.addend = addend;
        w.is_weak = is_weak;
        w.raw = rand64();
        w.off = 16'($urandom);
        return w;
    endfunction

    function automatic item_word_t fix_word(logic [63:0] raw, logic [15:0] off);
        item_word_t w;
        w.kind = KIND_FIX;
        w.slot = 12'($urandom);
        w.target = rand64();
        w.addend = rand64();
        w.is_weak = 1'($urandom);
        w.raw = raw;
        w.off = off;
        return w;
    endfunction

    // a loaded slot below import_count, or -1
    function automatic int pick_bound_slot();
        int s;
        if (sb.loaded_slots.size() == 0)
            return -1;
        for (int k = 0; k < 8; k++)
        begin
            s = sb.loaded_slots[$urandom_range(0, sb.loaded_slots.size() - 1)];
            if (s < int'(sb.import_count))
                return s;
        end
        return -1;
    endfunction

    // some import loads; else mostly in-page chains that follow their own next field; some stray offsets
    function automatic item_word_t make_random_item();
        int unsigned ps;
        int unsigned ic;
        int unsigned off;
        int unsigned nxt;
        int unsigned room;
        int unsigned pick;
        int          s;
        logic [23:0] idx;
        logic [35:0] tgt;
        logic [63:0] target;
        logic [63:0] addend;
        ps = sb.page_size;
        ic = sb.import_count;
        if ($urandom_range(0, 99) < 20)
        begin
            if (ic > 0 && $urandom_range(0, 1) == 1)
                s = $urandom_range(0, ic - 1);
            else
                s = $urandom_range(0, TABLE_DEPTH - 1);
            target = ($urandom_range(0, 9) == 0) ? 64'd0 : rand64();
            addend = ($urandom_range(0, 3) == 0) ? -64'($urandom_range(0, 255)) : rand64();
            return load_word(12'(s), target, addend, 1'($urandom));
        end
        if (ps >= 8 && $urandom_range(0, 99) < 85)
            off = chain_off;
        else
            off = $urandom_range(0, 65535);
        if (off + 8 <= ps)
        begin
            room = (ps - 8 - off) / 4;
            if (room > 4095)
                room = 4095;
            pick = $urandom_range(0, 99);
            if (pick < 70 && room > 0)
                nxt = $urandom_range(1, room);
            else if (pick < 85)
                nxt = 0;
            else
                nxt = $urandom_range(0, 4095);
        end
        else
        begin
            nxt = $urandom_range(0, 4095);
        end
        if (ps >= 8)
        begin
            if (nxt != 0 && off + 8 <= ps && off + nxt * 4 + 8 <= ps)
                chain_off = off + nxt * 4;
            else
                chain_off = $urandom_range(0, ps - 8);
        end
        if ($urandom_range(0, 99) < 45)
        begin
            s = pick_bound_slot();
            if (s >= 0 && $urandom_range(0, 99) < 85)
                idx = 24'(s);
            else if (ic < TABLE_DEPTH && $urandom_range(0, 1) == 1)
                idx = 24'($urandom_range(ic, TABLE_DEPTH - 1));
            else
                idx = 24'($urandom_range(TABLE_DEPTH, 24'hFF_FFFF));
            return fix_word(bind_word(idx, 8'($urandom), 12'(nxt)), 16'(off));
        end
        if ($urandom_range(0, 9) == 0)
            tgt = 36'($urandom_range(0, 255));
        else
            tgt = 36'(rand64());
        return fix_word(rebase_word(tgt, 8'($urandom), 12'(nxt)), 16'(off));
    endfunction

    task automatic send_word(item_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.kind <= w.kind;
        item_ch.import_slot <= w.slot;
        item_ch.import_target <= w.target;
        item_ch.import_addend <= w.addend;
        item_ch.import_weak <= w.is_weak;
        item_ch.raw_pointer <= w.raw;
        item_ch.offset_in_page <= w.off;
        do @(posedge clk); while (!item_ch.ready);
        sb.note_item(w);
    endtask

    task automatic drain_results();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [63:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.set_reg(idx, data);
    endtask

    task automatic configure_phase(int p);
        logic [63:0] pb;
        logic [63:0] lb;
        logic [63:0] gap;
        logic        fmt;
        int unsigned ps;
        int unsigned ic;
        case (p)
            0:
            begin
                pb = 64'h0000_0001_0000_0000;
                lb = 64'h0000_0001_0000_8000;
                fmt = FMT_VMADDR;
                ps = 16384;
                ic = 4096;
            end
            1:
            begin
                pb = 64'hFFFF_FFFF_FFFF_FFFF;
                lb = 64'd0;
                fmt = FMT_VMADDR;
                ps = 65535;
                ic = 0;
            end
            2:
            begin
                pb = 64'd0;
                lb = 64'hFFFF_FFFF_FFFF_FFFF;
                fmt = FMT_VMADDR;
                ps = 8;
                ic = 1;
            end
            3:
            begin
                pb = 64'd0;
                lb = 64'hFFFF_FFFF_FFFF_FFFF;
                fmt = FMT_RUNTIME_OFFSET;
                ps = 1;
                ic = 4096;
            end
            4:
            begin
                pb = rand64();
                lb = rand64();
                fmt = FMT_RUNTIME_OFFSET;
                ps = $urandom_range(8, 65535);
                ic = $urandom_range(0, 4096);
            end
            5:
            begin
                pb = rand64();
                gap = rand64() & 64'hF_FFFF_FFFF;
                lb = ($urandom_range(0, 1) == 1) ? pb + gap : pb - gap;
                fmt = FMT_VMADDR;
                ps = $urandom_range(1, 4096);
                ic = $urandom_range(1, 64);
            end
            default:
            begin
                pb = rand64();
                lb = rand64();
                fmt = 1'($urandom);
                ps = $urandom_range(1, 65535);
                ic = $urandom_range(0, 4096);
            end
        endcase
        write_reg(CFG_PREFERRED_BASE, pb);
        write_reg(CFG_LOADED_BASE, lb);
        write_reg(CFG_POINTER_FORMAT, 64'(fmt));
        write_reg(CFG_PAGE_SIZE, 64'(ps));
        write_reg(CFG_IMPORT_COUNT, 64'(ic));
        cfg_ch.valid <= 1'b0;
        case (p % 4)
            0:
            begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 77;
                stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                stall_pct = 77;
            end
            default:
            begin
                send_idle_pct = 14;
                stall_pct = 14;
            end
        endcase
        chain_off = 0;
    endtask

    // runs under phase 0 settings: page 16384, all 4096 imports counted
    task automatic run_directed();
        send_word(load_word(12'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
        send_word(load_word(12'd4095, 64'd0, 64'd5, 1'b1));
        send_word(load_word(12'd1, 64'd0, 64'd0, 1'b0));
        send_word(load_word(12'd2, 64'h0000_7000_0000_1234, 64'hFFFF_FFFF_FFFF_FFF8, 1'b0));
        send_word(fix_word(bind_word(24'd0, 8'hFF, 12'd1), 16'd0));
        send_word(fix_word(bind_word(24'd4095, 8'h00, 12'd0), 16'd16376));
        send_word(fix_word(bind_word(24'd1, 8'h12, 12'd3), 16'd100));
        send_word(fix_word(bind_word(24'd2, 8'h80, 12'hFFF), 16'd8));
        send_word(fix_word(bind_word(24'd2, 8'h00, 12'd1), 16'd16372));
        send_word(fix_word(bind_word(24'hFF_FFFF, 8'h01, 12'd1), 16'd0));
        send_word(fix_word(bind_word(24'd4096, 8'h01, 12'd1), 16'd0));
        send_word(fix_word(64'h7FFF_FFFF_FFFF_FFFF, 16'd0));
        send_word(fix_word(64'd0, 16'd0));
        send_word(fix_word(rebase_word(36'h1234, 8'hA5, 12'd4), 16'd16368));
        send_word(fix_word(rebase_word(36'h1234, 8'hA5, 12'd1), 16'hFFFF));
        send_word(fix_word(rebase_word(36'h1234, 8'hA5, 12'd1), 16'd16377));
        // reload then bind on the very next word
        send_word(load_word(12'd0, 64'h1000, 64'h10, 1'b0));
        send_word(fix_word(bind_word(24'd0, 8'h01, 12'd2), 16'd40));
        send_word(load_word(12'd4095, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b0));
        send_word(fix_word(bind_word(24'd4095, 8'hFF, 12'd1), 16'd16376));
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2)
                drain_results();
            send_word(make_random_item());
        end
    endtask

    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.fixed_value, result_ch.next_offset,
                                result_ch.chain_end, result_ch.status);
            result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.kind <= KIND_LOAD;
        item_ch.import_slot <= '0;
        item_ch.import_target <= '0;
        item_ch.import_addend <= '0;
        item_ch.import_weak <= 1'b0;
        item_ch.raw_pointer <= '0;
        item_ch.offset_in_page <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_PREFERRED_BASE;
        cfg_ch.data <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            configure_phase(p);
            if (p == 0)
                run_directed();
            run_random(RANDOM_PER_PHASE);
        end
        drain_results();
        repeat (8) @(posedge clk);
        sb.failures += sb.pending();
        $display("Covered %0d import loads and %0d pointer fixes over %0d register settings.",
                 sb.loads_seen, sb.fixes_seen, PHASES);
        $display("Status mix: ok %0d, outside %0d, bad import %0d, unresolved %0d, ",
                 sb.status_seen[ST_OK], sb.status_seen[ST_OUTSIDE],
                 sb.status_seen[ST_BAD_IMPORT], sb.status_seen[ST_UNRESOLVED],
                 "overflow %0d, slide fail %0d, leaves page %0d",
                 sb.status_seen[ST_OVERFLOW], sb.status_seen[ST_SLIDE_FAIL],
                 sb.status_seen[ST_NEXT_LEAVES]);
        if (sb.failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/cfp_pkg.sv
design/cfp_ifs.sv
design/cfp_front.sv
design/cfp_fifo.sv
design/cfp_back.sv
design/chained_fixup_pointer_rewrite.sv
verif/chained_fixup_pointer_rewrite_tb.sv
